// File: design/gfgmh_pkg.sv
// Shared constants, register codes and stage types for the frailty hazard pipeline.
package gfgmh_pkg;

    localparam int AGE_W     = 16;
    localparam int HAZ_W     = 48;
    localparam int CFG_W     = 40;
    localparam int N_W       = 9;
    localparam int EXP_TERMS = 14;
    localparam int INV_BITS  = 32;
    localparam int INV_STEPS = 2;
    localparam int INV_STGS  = INV_BITS / INV_STEPS;
    localparam int QUO_BITS  = 48;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    // Floor of 2^31 over ln 2 (one over 2 ln 2 in Q32), used to estimate the power of two.
    localparam logic [31:0] LN2_RECIP = 32'd3098164009;
    localparam logic [HAZ_W-1:0] HAZ_MAX = '1;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // Floor of 2^32 over k for the series divisions.
    localparam logic [31:0] RECIP_K [2:EXP_TERMS] = '{
        32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
        32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099,
        32'd306783378
    };

    typedef enum logic [1:0] {
        CFG_SCALE_A     = 2'd0,
        CFG_SLOPE_B     = 2'd1,
        CFG_MAKEHAM_C   = 2'd2,
        CFG_FRAILTY_VAR = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic [31:0]    r;
        logic [31:0]    term;
        logic [32:0]    sum;
    } t_exp_link;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [32:0]      sum;
        logic [HAZ_W-1:0] pv;
        logic             ps;
        logic [32:0]      rem;
        logic [31:0]      q;
    } t_inv_st;

    typedef struct packed {
        logic             zero_num;
        logic             sat_f;
        logic [HAZ_W-1:0] pv;
        logic             ps;
        logic [68:0]      d;
        logic [68:0]      rem;
        logic [23:0]      nlo;
        logic [QUO_BITS-1:0] q;
    } t_quo_st;

endpackage

// File: design/gamma_frailty_gompertz_makeham_hazard.sv
// Top level: pipelined gamma-frailty Gompertz-Makeham hazard with configuration registers.
//
// One age enters and one result leaves per cycle unless the result beat is stalled. The depth is
// set by the fourteen-term exponential series (the first term comes out of range reduction, each
// later term takes three stages), the 32-bit reciprocal divider (two quotient bits per stage) and
// the 48-bit final divider (one quotient bit per stage). When the result beat is stalled, the
// whole pipeline holds and the input channel is stalled in the same cycle.
module gamma_frailty_gompertz_makeham_hazard
    import gfgmh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [AGE_W-1:0] i_age,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [HAZ_W-1:0] o_hazard,
    output logic             o_saturated
);

    logic [39:0] r_scale_a;
    logic [31:0] r_slope_b;
    logic [39:0] r_makeham_c;
    logic [31:0] r_frailty_var;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_a     <= 40'd109951163;
            r_slope_b     <= 32'd429496730;
            r_makeham_c   <= 40'd0;
            r_frailty_var <= 32'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SCALE_A:     r_scale_a     <= i_cfg_data;
                CFG_SLOPE_B:     r_slope_b     <= i_cfg_data[31:0];
                CFG_MAKEHAM_C:   r_makeham_c   <= i_cfg_data;
                CFG_FRAILTY_VAR: r_frailty_var <= i_cfg_data[31:0];
                default:         r_scale_a     <= r_scale_a;
            endcase
        end
    end

    logic en;
    logic r_out_vld;
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // Range reduction: b*x, then split into n*ln2 + r.
    logic        r_p1_vld, r_p2_vld, r_p3_vld;
    logic [47:0] r_p1_prod;
    logic [39:0] r_p2_t;
    logic [63:0] r_p2_est;
    logic [N_W-1:0] r_p3_n;
    logic [32:0] r_p3_r;
    logic [N_W-1:0] n_est;
    logic [N_W-1:0] p4_n;
    logic [31:0] p4_r;

    assign n_est = r_p2_est[63:55];

    always_comb begin
        if (r_p3_r >= 33'(LN2_Q32)) begin
            p4_n = r_p3_n + 9'd1;
            p4_r = 32'(r_p3_r - 33'(LN2_Q32));
        end else begin
            p4_n = r_p3_n;
            p4_r = r_p3_r[31:0];
        end
    end

    logic      r_lk_vld [1:EXP_TERMS];
    t_exp_link r_lk     [1:EXP_TERMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_p3_vld    <= 1'b0;
            r_lk_vld[1] <= 1'b0;
        end else if (en) begin
            r_p1_vld    <= i_valid;
            r_p2_vld    <= r_p1_vld;
            r_p3_vld    <= r_p2_vld;
            r_lk_vld[1] <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_prod    <= 48'(r_slope_b) * 48'(i_age);
            r_p2_t       <= r_p1_prod[47:8];
            r_p2_est     <= 64'(r_p1_prod[47:16]) * 64'(LN2_RECIP);
            r_p3_n       <= n_est;
            r_p3_r       <= 33'(r_p2_t - 40'(n_est) * 40'(LN2_Q32));
            r_lk[1].n    <= p4_n;
            r_lk[1].r    <= p4_r;
            r_lk[1].term <= p4_r;
            r_lk[1].sum  <= ONE_Q32 + 33'(p4_r);
        end
    end

    // Exponential series, three stages per term.
    logic      r_ea_vld [2:EXP_TERMS];
    logic      r_eb_vld [2:EXP_TERMS];
    t_exp_link r_ea_lk  [2:EXP_TERMS];
    t_exp_link r_eb_lk  [2:EXP_TERMS];
    logic [31:0] r_ea_x [2:EXP_TERMS];
    logic [31:0] r_eb_x [2:EXP_TERMS];
    logic [31:0] r_eb_q [2:EXP_TERMS];

    for (genvar k = 2; k <= EXP_TERMS; k++) begin : g_exp
        logic [63:0] a_prod;
        logic [63:0] b_prod;
        logic [32:0] c_rem;
        logic [31:0] c_q;

        assign a_prod = 64'(r_lk[k-1].term) * 64'(r_lk[k-1].r);
        assign b_prod = 64'(r_ea_x[k]) * 64'(RECIP_K[k]);

        always_comb begin
            c_rem = 33'(r_eb_x[k]) - 33'(r_eb_q[k]) * 33'(k);
            if (c_rem >= 33'(k)) begin
                c_q = r_eb_q[k] + 32'd1;
            end else begin
                c_q = r_eb_q[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ea_vld[k] <= 1'b0;
                r_eb_vld[k] <= 1'b0;
                r_lk_vld[k] <= 1'b0;
            end else if (en) begin
                r_ea_vld[k] <= r_lk_vld[k-1];
                r_eb_vld[k] <= r_ea_vld[k];
                r_lk_vld[k] <= r_eb_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ea_lk[k]   <= r_lk[k-1];
                r_ea_x[k]    <= a_prod[63:32];
                r_eb_lk[k]   <= r_ea_lk[k];
                r_eb_x[k]    <= r_ea_x[k];
                r_eb_q[k]    <= b_prod[63:32];
                r_lk[k].n    <= r_eb_lk[k].n;
                r_lk[k].r    <= r_eb_lk[k].r;
                r_lk[k].term <= c_q;
                r_lk[k].sum  <= r_eb_lk[k].sum + 33'(c_q);
            end
        end
    end

    // Plain hazard term a*m*2^n, saturated at the output range.
    logic        r_q1_vld, r_q2_vld;
    logic [N_W-1:0] r_q1_n, r_q2_n;
    logic [32:0] r_q1_sum, r_q2_sum;
    logic [52:0] r_q1_pl, r_q1_ph;
    logic [72:0] r_q2_p;
    logic [8:0]  sh_up, sh_dn;
    logic [HAZ_W-1:0] q3_pv;
    logic        q3_ps;

    always_comb begin
        sh_up = r_q2_n - 9'd40;
        sh_dn = 9'd40 - r_q2_n;
        if (r_q2_n > 9'd88) begin
            q3_ps = (r_q2_p != '0);
        end else begin
            q3_ps = ((r_q2_p >> (9'd88 - r_q2_n)) != '0);
        end
        if (r_q2_n >= 9'd40) begin
            q3_pv = 48'(r_q2_p << sh_up);
        end else begin
            q3_pv = 48'(r_q2_p >> sh_dn);
        end
    end

    // Reciprocal of m, two quotient bits per stage.
    logic    r_d1_vld [0:INV_STGS];
    t_inv_st r_d1     [0:INV_STGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_vld    <= 1'b0;
            r_q2_vld    <= 1'b0;
            r_d1_vld[0] <= 1'b0;
        end else if (en) begin
            r_q1_vld    <= r_lk_vld[EXP_TERMS];
            r_q2_vld    <= r_q1_vld;
            r_d1_vld[0] <= r_q2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_n       <= r_lk[EXP_TERMS].n;
            r_q1_sum     <= r_lk[EXP_TERMS].sum;
            r_q1_pl      <= 53'(r_scale_a[19:0]) * 53'(r_lk[EXP_TERMS].sum);
            r_q1_ph      <= 53'(r_scale_a[39:20]) * 53'(r_lk[EXP_TERMS].sum);
            r_q2_n       <= r_q1_n;
            r_q2_sum     <= r_q1_sum;
            r_q2_p       <= 73'(r_q1_pl) + {r_q1_ph, 20'b0};
            r_d1[0].n    <= r_q2_n;
            r_d1[0].sum  <= r_q2_sum;
            r_d1[0].pv   <= q3_pv;
            r_d1[0].ps   <= q3_ps;
            r_d1[0].rem  <= 33'h0_FFFF_FFFF;
            r_d1[0].q    <= '0;
        end
    end

    for (genvar s = 1; s <= INV_STGS; s++) begin : g_inv
        t_inv_st nxt;
        logic [33:0] trial;

        always_comb begin
            nxt   = r_d1[s-1];
            trial = '0;
            for (int j = 0; j < INV_STEPS; j++) begin
                trial = {nxt.rem, 1'b1};
                if (trial >= 34'(nxt.sum)) begin
                    nxt.rem = 33'(trial - 34'(nxt.sum));
                    nxt.q   = {nxt.q[30:0], 1'b1};
                end else begin
                    nxt.rem = trial[32:0];
                    nxt.q   = {nxt.q[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_vld[s] <= 1'b0;
            end else if (en) begin
                r_d1_vld[s] <= r_d1_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d1[s] <= nxt;
            end
        end
    end

    // Frailty denominator D = b*g + (a*s*h >> 36) and numerator a*b.
    logic        r_g1_vld, r_g2_vld, r_g3_vld, r_g4_vld, r_g5_vld;
    logic [32:0] r_g1_g, r_g1_h;
    logic [71:0] r_g1_ab, r_g2_ab, r_g3_ab, r_g4_ab, r_g5_ab;
    logic [HAZ_W-1:0] r_g1_pv, r_g2_pv, r_g3_pv, r_g4_pv, r_g5_pv;
    logic        r_g1_ps, r_g2_ps, r_g3_ps, r_g4_ps, r_g5_ps;
    logic [64:0] r_g2_bg, r_g3_bg, r_g4_bg;
    logic [63:0] r_g2_fh;
    logic [71:0] r_g3_pp0, r_g3_pp1;
    logic [103:0] r_g4_afh;
    logic [68:0] r_g5_d;
    logic [32:0] g1_inv, g1_g;
    t_inv_st     d1_end;

    assign d1_end = r_d1[INV_STGS];

    always_comb begin
        if (d1_end.sum == ONE_Q32) begin
            g1_inv = ONE_Q32;
        end else begin
            g1_inv = {1'b0, d1_end.q};
        end
        if (d1_end.n[8:6] == 3'd0) begin
            g1_g = g1_inv >> d1_end.n[5:0];
        end else begin
            g1_g = '0;
        end
    end

    logic    r_d2_vld [0:QUO_BITS];
    t_quo_st r_d2     [0:QUO_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_vld    <= 1'b0;
            r_g2_vld    <= 1'b0;
            r_g3_vld    <= 1'b0;
            r_g4_vld    <= 1'b0;
            r_g5_vld    <= 1'b0;
            r_d2_vld[0] <= 1'b0;
        end else if (en) begin
            r_g1_vld    <= r_d1_vld[INV_STGS];
            r_g2_vld    <= r_g1_vld;
            r_g3_vld    <= r_g2_vld;
            r_g4_vld    <= r_g3_vld;
            r_g5_vld    <= r_g4_vld;
            r_d2_vld[0] <= r_g5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1_g   <= g1_g;
            r_g1_h   <= ONE_Q32 - g1_g;
            r_g1_ab  <= 72'(r_scale_a) * 72'(r_slope_b);
            r_g1_pv  <= d1_end.pv;
            r_g1_ps  <= d1_end.ps;

            r_g2_bg  <= 65'(r_slope_b) * 65'(r_g1_g);
            r_g2_fh  <= 64'(65'(r_frailty_var) * 65'(r_g1_h));
            r_g2_ab  <= r_g1_ab;
            r_g2_pv  <= r_g1_pv;
            r_g2_ps  <= r_g1_ps;

            r_g3_pp0 <= 72'(r_scale_a) * 72'(r_g2_fh[31:0]);
            r_g3_pp1 <= 72'(r_scale_a) * 72'(r_g2_fh[63:32]);
            r_g3_bg  <= r_g2_bg;
            r_g3_ab  <= r_g2_ab;
            r_g3_pv  <= r_g2_pv;
            r_g3_ps  <= r_g2_ps;

            r_g4_afh <= 104'(r_g3_pp0) + {r_g3_pp1, 32'b0};
            r_g4_bg  <= r_g3_bg;
            r_g4_ab  <= r_g3_ab;
            r_g4_pv  <= r_g3_pv;
            r_g4_ps  <= r_g3_ps;

            r_g5_d   <= 69'(r_g4_bg) + 69'(r_g4_afh[103:36]);
            r_g5_ab  <= r_g4_ab;
            r_g5_pv  <= r_g4_pv;
            r_g5_ps  <= r_g4_ps;

            r_d2[0].zero_num <= (r_g5_ab == '0);
            r_d2[0].sat_f    <= (r_g5_d == '0) || (93'(r_g5_ab) >= {r_g5_d, 24'b0});
            r_d2[0].pv       <= r_g5_pv;
            r_d2[0].ps       <= r_g5_ps;
            r_d2[0].d        <= r_g5_d;
            r_d2[0].rem      <= 69'(r_g5_ab[71:24]);
            r_d2[0].nlo      <= r_g5_ab[23:0];
            r_d2[0].q        <= '0;
        end
    end

    // Final quotient (a*b*2^24) / D, one bit per stage.
    for (genvar s = 1; s <= QUO_BITS; s++) begin : g_quo
        t_quo_st     nxt;
        logic [69:0] trial;

        always_comb begin
            nxt     = r_d2[s-1];
            trial   = {r_d2[s-1].rem, r_d2[s-1].nlo[23]};
            nxt.nlo = {r_d2[s-1].nlo[22:0], 1'b0};
            if (trial >= 70'(r_d2[s-1].d)) begin
                nxt.rem = 69'(trial - 70'(r_d2[s-1].d));
                nxt.q   = {r_d2[s-1].q[QUO_BITS-2:0], 1'b1};
            end else begin
                nxt.rem = trial[68:0];
                nxt.q   = {r_d2[s-1].q[QUO_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_vld[s] <= 1'b0;
            end else if (en) begin
                r_d2_vld[s] <= r_d2_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d2[s] <= nxt;
            end
        end
    end

    // Term selection, Makeham constant and output clamp.
    t_quo_st          d2_end;
    logic [HAZ_W-1:0] fin_g;
    logic             fin_s;
    logic [HAZ_W:0]   fin_total;
    logic [HAZ_W-1:0] n_out_haz;
    logic             n_out_sat;
    logic [HAZ_W-1:0] r_out_haz;
    logic             r_out_sat;

    assign d2_end = r_d2[QUO_BITS];

    always_comb begin
        if (r_frailty_var == '0) begin
            fin_g = d2_end.pv;
            fin_s = d2_end.ps;
        end else if (d2_end.zero_num) begin
            fin_g = '0;
            fin_s = 1'b0;
        end else begin
            fin_g = d2_end.q;
            fin_s = d2_end.sat_f;
        end
        fin_total = 49'(fin_g) + 49'(r_makeham_c[39:8]);
        if (fin_s || fin_total[HAZ_W]) begin
            n_out_haz = HAZ_MAX;
            n_out_sat = 1'b1;
        end else begin
            n_out_haz = fin_total[HAZ_W-1:0];
            n_out_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_d2_vld[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_haz <= n_out_haz;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_hazard    = r_out_haz;
    assign o_saturated = r_out_sat;

endmodule

// File: design/gfgmh_chk.sv
// Port checker for the frailty hazard pipeline and its bind to the top level.
module gfgmh_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_wr_en,
    input logic [1:0]  i_cfg_index,
    input logic [39:0] i_cfg_data,
    input logic        i_valid,
    input logic        o_stall,
    input logic [15:0] i_age,
    input logic        o_valid,
    input logic        i_stall,
    input logic [47:0] o_hazard,
    input logic        o_saturated
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hazard) && $stable(o_saturated))
        else $error("stalled result beat changed");

    // A clamped result always reads as the full-scale hazard.
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_hazard == 48'hFFFF_FFFF_FFFF)
        else $error("saturated flag without full-scale hazard");

    // The input side is held back only by a waiting result beat.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

endmodule

bind gamma_frailty_gompertz_makeham_hazard gfgmh_chk u_gfgmh_chk (.*);
